[hdl/rtwa_pkg.sv]
// ----------------------------------------------------------------------------
// rtwa_pkg
// Shared constants, codes and control types of the registration table.
// ----------------------------------------------------------------------------
package rtwa_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int KEY_BITS_DEF = 64;

  localparam int KEY_W    = 64;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int LIFE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int EXP_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ADDR_W-1:0] SRV_ADDR_RST = 32'h7F00_0001;
  localparam logic [PORT_W-1:0] SRV_PORT_RST = 16'd5003;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TICK = 2'd2;

  localparam logic REQ_REG  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRV_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRV_PORT = 2'd1;

  localparam logic [EXP_W-1:0] EXP_MAX = 7'h7F;

  typedef struct packed {
    logic load_req;
    logic read;
    logic clear_wr;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic out_free;
  } sts_t;

endpackage

[hdl/rtwa_ram.sv]
// ----------------------------------------------------------------------------
// rtwa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rtwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/rtwa_ctrl.sv]
// ----------------------------------------------------------------------------
// rtwa_ctrl
// Sequencer for clearing, table sweeps, commit and result hand-off.
// ----------------------------------------------------------------------------
module rtwa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtwa_pkg::sts_t sts,
  output rtwa_pkg::cmd_t cmd
);
  import rtwa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.read = 1'b1;
        if (sts.ptr_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

[hdl/rtwa_dp.sv]
// ----------------------------------------------------------------------------
// rtwa_dp
// Table storage, sweep pointer, match and aging logic, result register.
// ----------------------------------------------------------------------------
module rtwa_dp #(
  parameter int ENTRIES  = rtwa_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = rtwa_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtwa_pkg::cmd_t                      cmd,
  output rtwa_pkg::sts_t                      sts,
  input  logic                                in_req_type,
  input  logic [rtwa_pkg::KEY_W-1:0]          in_user_key,
  input  logic [rtwa_pkg::ADDR_W-1:0]         in_user_address,
  input  logic [rtwa_pkg::LIFE_W-1:0]         in_lifetime,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rtwa_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_was_update,
  output logic [rtwa_pkg::SLOT_W-1:0]         out_slot_index,
  output logic [rtwa_pkg::ADDR_W-1:0]         out_assigned_address,
  output logic [rtwa_pkg::PORT_W-1:0]         out_assigned_port,
  output logic [rtwa_pkg::EXP_W-1:0]          out_expired_count,
  input  logic                                cfg_we,
  input  logic [rtwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtwa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rtwa_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W = 1 + KEY_BITS + ADDR_W + LIFE_W;
  localparam int LIFE_LO = 0;
  localparam int ADDR_LO = LIFE_W;
  localparam int KEY_LO  = LIFE_W + ADDR_W;
  localparam int VLD_B   = LIFE_W + ADDR_W + KEY_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // config registers
  logic [ADDR_W-1:0] srv_addr_r;
  logic [PORT_W-1:0] srv_port_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srv_addr_r <= SRV_ADDR_RST;
      srv_port_r <= SRV_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRV_ADDR: srv_addr_r <= cfg_data[ADDR_W-1:0];
        CFG_SRV_PORT: srv_port_r <= cfg_data[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic                req_type_r;
  logic [KEY_BITS-1:0] key_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [LIFE_W-1:0]   life_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      key_r      <= in_user_key[KEY_BITS-1:0];
      addr_r     <= in_user_address;
      life_r     <= in_lifetime;
    end
  end

  // sweep pointer and evaluation stage
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] ev_idx_r;
  logic             ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      ev_r  <= 1'b0;
    end else begin
      ev_r <= cmd.read;
      if (cmd.load_req) begin
        ptr_r <= '0;
      end else if (cmd.read || cmd.clear_wr) begin
        ptr_r <= (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      ev_idx_r <= ptr_r;
    end
  end

  // table memory
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;

  rtwa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.read),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  logic                ev_vld;
  logic [KEY_BITS-1:0] ev_key;
  logic [ADDR_W-1:0]   ev_addr;
  logic [LIFE_W-1:0]   ev_life;
  logic [LIFE_W-1:0]   life_dec;
  logic                tick_wr;
  logic                expire;

  assign ev_vld   = rd_data[VLD_B];
  assign ev_key   = rd_data[KEY_LO +: KEY_BITS];
  assign ev_addr  = rd_data[ADDR_LO +: ADDR_W];
  assign ev_life  = rd_data[LIFE_LO +: LIFE_W];
  assign life_dec = ev_life - 1'b1;
  assign tick_wr  = ev_r && (req_type_r == REQ_TICK) && ev_vld && (ev_life != '0);
  assign expire   = tick_wr && (life_dec == '0);

  // lookup trackers
  logic             hit_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;
  logic [EXP_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ev_r) begin
      if (req_type_r == REQ_REG) begin
        if (ev_vld && (ev_key == key_r) && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= ev_idx_r;
        end
        if (!ev_vld && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= ev_idx_r;
        end
      end else if (expire && (cnt_r != EXP_MAX)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = '0;
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (tick_wr) begin
      wr_en   = 1'b1;
      wr_addr = ev_idx_r;
      wr_data = {!expire, ev_key, ev_addr, life_dec};
    end else if (cmd.commit && (req_type_r == REQ_REG) && (hit_r || free_r)) begin
      wr_en   = 1'b1;
      wr_addr = hit_r ? hit_idx_r : free_idx_r;
      wr_data = {1'b1, key_r, addr_r, life_r};
    end
  end

  // result
  logic [STATUS_W-1:0] res_status;
  logic                res_upd;
  logic [SLOT_W-1:0]   res_slot;
  logic [ADDR_W-1:0]   res_addr;
  logic [PORT_W-1:0]   res_port;
  logic [EXP_W-1:0]    res_exp;

  always_comb begin
    res_status = ST_FULL;
    res_upd    = 1'b0;
    res_slot   = '0;
    res_addr   = '0;
    res_port   = '0;
    res_exp    = '0;
    if (req_type_r == REQ_TICK) begin
      res_status = ST_TICK;
      res_exp    = cnt_r;
    end else if (hit_r || free_r) begin
      res_status = ST_OK;
      res_upd    = hit_r;
      res_slot   = hit_r ? SLOT_W'(hit_idx_r) : SLOT_W'(free_idx_r);
      res_addr   = srv_addr_r;
      res_port   = srv_port_r;
    end
  end

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_upd_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [PORT_W-1:0]   out_port_r;
  logic [EXP_W-1:0]    out_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status;
      out_upd_r    <= res_upd;
      out_slot_r   <= res_slot;
      out_addr_r   <= res_addr;
      out_port_r   <= res_port;
      out_exp_r    <= res_exp;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_was_update       = out_upd_r;
  assign out_slot_index       = out_slot_r;
  assign out_assigned_address = out_addr_r;
  assign out_assigned_port    = out_port_r;
  assign out_expired_count    = out_exp_r;

  assign sts.ptr_last = (ptr_r == LAST_IDX);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

[hdl/registration_table_with_aging.sv]
// ----------------------------------------------------------------------------
// registration_table_with_aging
// User registration table with key lookup, free-entry fill and tick aging.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | req_type, user_key, user_address, lifetime
//  out     | output    | out_valid/out_ready| status, was_update, slot_index,
//          |           |                    | assigned_address, assigned_port, expired_count
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  every item sweeps the whole table through the single read port of the table RAM;
//  a new item is taken only after the last one is loaded into the result register.
//  after reset a clearing pass writes every entry invalid;
//  in_ready stays low during it, cfg writes are taken at any time.
//  a result waiting on out_ready stalls only the final hand-off of the next item.
// ----------------------------------------------------------------------------
module registration_table_with_aging #(
  parameter int ENTRIES  = rtwa_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = rtwa_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [rtwa_pkg::KEY_W-1:0]      in_user_key,
  input  logic [rtwa_pkg::ADDR_W-1:0]     in_user_address,
  input  logic [rtwa_pkg::LIFE_W-1:0]     in_lifetime,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rtwa_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_was_update,
  output logic [rtwa_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [rtwa_pkg::ADDR_W-1:0]     out_assigned_address,
  output logic [rtwa_pkg::PORT_W-1:0]     out_assigned_port,
  output logic [rtwa_pkg::EXP_W-1:0]      out_expired_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtwa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rtwa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rtwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtwa_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_req_type          (in_req_type),
    .in_user_key          (in_user_key),
    .in_user_address      (in_user_address),
    .in_lifetime          (in_lifetime),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_was_update       (out_was_update),
    .out_slot_index       (out_slot_index),
    .out_assigned_address (out_assigned_address),
    .out_assigned_port    (out_assigned_port),
    .out_expired_count    (out_expired_count),
    .cfg_we               (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

endmodule

[hdl/rtwa_checker.sv]
// ----------------------------------------------------------------------------
// rtwa_checker
// Port-level checks of the registration table, bound to the top level.
// ----------------------------------------------------------------------------
module rtwa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rtwa_pkg::STATUS_W-1:0]   out_status,
  input logic                            out_was_update,
  input logic [rtwa_pkg::SLOT_W-1:0]     out_slot_index,
  input logic [rtwa_pkg::ADDR_W-1:0]     out_assigned_address,
  input logic [rtwa_pkg::PORT_W-1:0]     out_assigned_port,
  input logic [rtwa_pkg::EXP_W-1:0]      out_expired_count
);
  import rtwa_pkg::*;

  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot_index) && $stable(out_expired_count))
    else $error("stalled result changed");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> !out_was_update &&
      (out_slot_index == '0) && (out_assigned_address == '0) &&
      (out_assigned_port == '0) && (out_expired_count == '0))
    else $error("table full result carries data");

  a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_TICK) |-> !out_was_update &&
      (out_slot_index == '0) && (out_assigned_address == '0) &&
      (out_assigned_port == '0))
    else $error("tick result carries registration data");

endmodule

bind registration_table_with_aging rtwa_checker u_rtwa_checker (.*);

[test/tb_registration_table_with_aging.sv]
// ----------------------------------------------------------------------------
// tb_registration_table_with_aging
// Self-checking bench for the registration table with tick aging.
// A queue-fed driver offers register requests and ticks while a monitor
// compares every result with a cycle-free model of the table. The run goes
// through several server settings, random idling on both sides, a long output
// stall, table-full and mass-expiry sequences.
// ----------------------------------------------------------------------------
module tb_registration_table_with_aging;
  import rtwa_pkg::*;

  localparam int N_ENTRIES      = ENTRIES_DEF;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 600;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 148;
  localparam int POOL_SIZE      = 96;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] address;
    logic [LIFE_W-1:0] lifetime;
  } reg_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                was_update;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   address;
    logic [PORT_W-1:0]   port;
    logic [EXP_W-1:0]    expired;
  } reg_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_REG;
  logic [KEY_W-1:0]      in_user_key = '0;
  logic [ADDR_W-1:0]     in_user_address = '0;
  logic [LIFE_W-1:0]     in_lifetime = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_was_update;
  logic [SLOT_W-1:0]     out_slot_index;
  logic [ADDR_W-1:0]     out_assigned_address;
  logic [PORT_W-1:0]     out_assigned_port;
  logic [EXP_W-1:0]      out_expired_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRV_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  registration_table_with_aging u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_user_key          (in_user_key),
    .in_user_address      (in_user_address),
    .in_lifetime          (in_lifetime),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_was_update       (out_was_update),
    .out_slot_index       (out_slot_index),
    .out_assigned_address (out_assigned_address),
    .out_assigned_port    (out_assigned_port),
    .out_expired_count    (out_expired_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // table image and server settings
  bit                tbl_valid [N_ENTRIES];
  logic [KEY_W-1:0]  tbl_key   [N_ENTRIES];
  logic [ADDR_W-1:0] tbl_addr  [N_ENTRIES];
  logic [LIFE_W-1:0] tbl_life  [N_ENTRIES];
  logic [ADDR_W-1:0] srv_addr = SRV_ADDR_RST;
  logic [PORT_W-1:0] srv_port = SRV_PORT_RST;

  reg_request_t      pending_requests [$];
  reg_reply_t        expected_replies [$];
  reg_request_t      offered;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int accepted_items = 0;
  int replies_seen = 0;
  int queued_in_phase = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  int n_added = 0;
  int n_updates = 0;
  int n_full = 0;
  int n_ticks = 0;
  int n_aged_out = 0;
  int max_aged_out = 0;
  int n_cfg_writes = 0;

  function automatic reg_reply_t serve_request(reg_request_t r);
    reg_reply_t rep;
    int freed;
    int slot;
    rep = '0;
    freed = 0;
    slot = -1;
    if (r.req_type == REQ_TICK) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_life[i] != '0) begin
          tbl_life[i] = tbl_life[i] - 1'b1;
          if (tbl_life[i] == '0) begin
            tbl_valid[i] = 1'b0;
            if (freed < EXP_MAX) freed++;
          end
        end
      end
      rep.status = ST_TICK;
      rep.expired = EXP_W'(freed);
      n_ticks++;
      n_aged_out += freed;
      if (freed > max_aged_out) max_aged_out = freed;
      return rep;
    end
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (slot < 0 && tbl_valid[i] && tbl_key[i] == r.key) slot = i;
    end
    if (slot >= 0) begin
      rep.was_update = 1'b1;
      n_updates++;
    end else begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (slot < 0 && !tbl_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        tbl_valid[slot] = 1'b1;
        tbl_key[slot] = r.key;
        n_added++;
      end
    end
    if (slot < 0) begin
      rep.status = ST_FULL;
      n_full++;
    end else begin
      tbl_addr[slot] = r.address;
      tbl_life[slot] = r.lifetime;
      rep.status = ST_OK;
      rep.slot = SLOT_W'(slot);
      rep.address = srv_addr;
      rep.port = srv_port;
    end
    return rep;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(serve_request(offered));
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_req_type <= offered.req_type;
          in_user_key <= offered.key;
          in_user_address <= offered.address;
          in_lifetime <= offered.lifetime;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    reg_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $error("result transfer with nothing outstanding, status %0d", out_status);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("was_update", 64'(want.was_update), 64'(out_was_update));
          check_field("slot_index", 64'(want.slot), 64'(out_slot_index));
          check_field("assigned_address", 64'(want.address), 64'(out_assigned_address));
          check_field("assigned_port", 64'(want.port), 64'(out_assigned_port));
          check_field("expired_count", 64'(want.expired), 64'(out_expired_count));
        end
      end
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_register(logic [KEY_W-1:0] key, logic [ADDR_W-1:0] address,
                                logic [LIFE_W-1:0] life);
    reg_request_t r;
    r.req_type = REQ_REG;
    r.key = key;
    r.address = address;
    r.lifetime = life;
    pending_requests.push_back(r);
    queued_in_phase++;
  endtask

  // fields other than the type are don't-care on a tick
  task automatic queue_tick();
    reg_request_t r;
    r.req_type = REQ_TICK;
    r.key = {$urandom, $urandom};
    r.address = $urandom;
    r.lifetime = LIFE_W'($urandom);
    pending_requests.push_back(r);
    queued_in_phase++;
  endtask

  function automatic logic [LIFE_W-1:0] random_lifetime();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 75) return LIFE_W'($urandom_range(1, 8));
    if (roll < 92) return LIFE_W'($urandom_range(9, 200));
    return LIFE_W'($urandom_range(65535));
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SRV_ADDR) srv_addr = data;
    else if (idx == CFG_SRV_PORT) srv_port = data[PORT_W-1:0];
    n_cfg_writes++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [KEY_W-1:0] key_c;
    logic [LIFE_W-1:0] burst_life;
    int pick;
    int burst_len;
    int base;
    int tick_pct;
    int mark;
    bit fresh;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};
    key_a = {$urandom, $urandom};
    key_b = {$urandom, $urandom};
    key_c = {$urandom, $urandom};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset server settings
    queue_tick();
    queue_register('0, '0, '0);
    queue_register('1, '1, '1);
    queue_register('0, 32'h1234_5678, 16'd3);
    queue_register(key_a, $urandom, 16'd1);
    queue_register(key_b, $urandom, 16'd2);
    queue_tick();
    queue_tick();
    queue_register(key_c, $urandom, 16'd5);
    // re-register over a stale expired slot
    queue_register(key_a, $urandom, '0);
    queue_register('1, $urandom, 16'd1);
    queue_register(key_c, $urandom, '0);
    queue_tick();
    pending_requests.push_back('{REQ_TICK, '1, '1, '1});
    queue_register('1, '0, 16'h8000);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 54;
      end else if (p < 6) begin
        send_idle_pct = 54;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (p)
        0: begin
          write_register(CFG_SRV_ADDR, '0);
          write_register(CFG_SRV_PORT, 32'hFFFF_0000);
        end
        1: begin
          write_register(CFG_SRV_ADDR, '1);
          write_register(CFG_SRV_PORT, '1);
        end
        2: begin
          write_register(CFG_SRV_ADDR, $urandom);
          write_register(CFG_SPARE_A, $urandom);
          write_register(CFG_SPARE_B, $urandom);
        end
        default: begin
          write_register(CFG_SRV_ADDR, $urandom);
          write_register(CFG_SRV_PORT, $urandom);
        end
      endcase
      cfg_valid <= 1'b0;

      queued_in_phase = 0;
      tick_pct = 8 + 6 * (p % 4);

      // overfill with short-lived users, then age them all out together
      if (p == 0) begin
        for (int k = 0; k < N_ENTRIES + 2; k++) queue_register({$urandom, $urandom}, $urandom, 16'd2);
        queue_tick();
        queue_tick();
      end

      while (queued_in_phase < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          burst_len = $urandom_range(1, N_ENTRIES);
          burst_life = LIFE_W'($urandom_range(1, 4));
          base = $urandom_range(POOL_SIZE - 1);
          fresh = 1'($urandom_range(1));
          for (int k = 0; k < burst_len; k++) begin
            queue_register(fresh ? {$urandom, $urandom} : key_pool[(base + k) % POOL_SIZE],
                           $urandom, burst_life);
          end
          repeat ($urandom_range(1, burst_life + 1)) queue_tick();
        end else if (pick < 11) begin
          if ($urandom_range(1)) queue_tick();
          else queue_register(key_pool[$urandom_range(POOL_SIZE - 1)], $urandom,
                              LIFE_W'($urandom_range(65535)));
        end else if ($urandom_range(99) < tick_pct) begin
          queue_tick();
        end else if ($urandom_range(9) == 0) begin
          queue_register({$urandom, $urandom}, $urandom, LIFE_W'($urandom_range(1, 8)));
        end else begin
          queue_register(key_pool[$urandom_range(POOL_SIZE - 1)], $urandom, random_lifetime());
        end
      end

      // long output stall while requests keep coming
      if (p == 6) begin
        mark = accepted_items + 30;
        while (accepted_items < mark) @(posedge clk);
        hold_request = 1'b1;
      end
      wait_drained();
    end

    repeat (N_ENTRIES + 8) @(posedge clk);
    $display("%0d requests checked: %0d added, %0d refreshed, %0d rejected full, %0d ticks",
             replies_seen, n_added, n_updates, n_full, n_ticks);
    $display("%0d entries aged out (up to %0d in one tick), %0d server register writes",
             n_aged_out, max_aged_out, n_cfg_writes);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
